// ----- sv/idft2d_pkg.sv -----
// shared constants, types and helpers of the 2d inverse dft block
package idft2d_pkg;

  // grid geometry
  localparam int GRID_LOG2  = 4;
  localparam int GRID_SIZE  = 1 << GRID_LOG2;
  localparam int ADDR_W     = 2 * GRID_LOG2;
  localparam int GRID_AREA  = GRID_SIZE * GRID_SIZE;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(GRID_AREA - 1);
  localparam logic [GRID_LOG2-1:0] COL_LAST = GRID_LOG2'(GRID_SIZE - 1);

  // datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int TW_W       = 16;
  localparam int PROD_W     = SAMPLE_W + TW_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int ACC_W      = 48;
  localparam int OUT_W      = 16;
  localparam int NORM_SHIFT = 2 * GRID_LOG2;
  localparam int Q_W        = ACC_W - NORM_SHIFT + 1;

  // opcodes of an input item
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // last value of the drain counter before the normalize step
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  typedef logic signed [TW_W-1:0] tw_t;

  // q1.15 twiddle table, entry k = cos/sin(2*pi*k/16)
  localparam tw_t TW_COS [GRID_SIZE] = '{
    16'sd32767,  16'sd30274,  16'sd23170,  16'sd12540,
    16'sd0,     -16'sd12540, -16'sd23170, -16'sd30274,
    -16'sd32768, -16'sd30274, -16'sd23170, -16'sd12540,
    16'sd0,      16'sd12540,  16'sd23170,  16'sd30274
  };
  localparam tw_t TW_SIN [GRID_SIZE] = '{
    16'sd0,      16'sd12540,  16'sd23170,  16'sd30274,
    16'sd32767,  16'sd30274,  16'sd23170,  16'sd12540,
    16'sd0,     -16'sd12540, -16'sd23170, -16'sd30274,
    -16'sd32768, -16'sd30274, -16'sd23170, -16'sd12540
  };

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_NORM
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic mem_we;
    logic latch;
    logic issue;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_issue;
  } dp_sts_t;

  // divide by grid area with round half up, then saturate to 16 bits
  function automatic logic signed [OUT_W-1:0] norm_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0]   biased;
    logic signed [ACC_W:0]   shifted;
    logic signed [Q_W-1:0]   q;
    logic signed [Q_W-1:0]   sat_max;
    logic signed [Q_W-1:0]   sat_min;
    logic signed [OUT_W-1:0] res;
    sat_max = Q_W'(2 ** (OUT_W - 1) - 1);
    sat_min = -(Q_W'(2 ** (OUT_W - 1)));
    biased  = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W + 1)'(1 << (NORM_SHIFT - 1)));
    shifted = biased >>> NORM_SHIFT;
    q       = shifted[Q_W-1:0];
    if (q > sat_max) begin
      res = sat_max[OUT_W-1:0];
    end else if (q < sat_min) begin
      res = sat_min[OUT_W-1:0];
    end else begin
      res = q[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- sv/idft2d_ctrl.sv -----
// controller state machine sequencing loads and grid sweeps
module idft2d_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_opcode,
  input  idft2d_pkg::dp_sts_t sts,
  output idft2d_pkg::dp_cmd_t cmd,
  output logic               busy,
  output logic               out_valid
);
  import idft2d_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic       out_valid_r, out_valid_nxt;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    drain_nxt     = drain_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_opcode == OP_LOAD) begin
            cmd.mem_we = 1'b1;
          end else begin
            cmd.latch = 1'b1;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          drain_nxt = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == DRAIN_LAST) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd.load_out  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- sv/idft2d_dp.sv -----
// datapath: spectrum store, twiddle lookup, complex mac and normalize
module idft2d_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  idft2d_pkg::dp_cmd_t                    cmd,
  output idft2d_pkg::dp_sts_t                    sts,
  input  logic [idft2d_pkg::GRID_LOG2-1:0]       in_row,
  input  logic [idft2d_pkg::GRID_LOG2-1:0]       in_col,
  input  logic signed [idft2d_pkg::SAMPLE_W-1:0] in_sample_real,
  input  logic signed [idft2d_pkg::SAMPLE_W-1:0] in_sample_imag,
  output logic signed [idft2d_pkg::OUT_W-1:0]    out_real,
  output logic signed [idft2d_pkg::OUT_W-1:0]    out_imag
);
  import idft2d_pkg::*;

  logic [2*SAMPLE_W-1:0] mem [GRID_AREA];

  logic [GRID_LOG2-1:0]       row_r, col_r, k_r;
  logic [ADDR_W-1:0]          cnt_r;
  logic                       v1_r, v2_r, v3_r;
  logic signed [SAMPLE_W-1:0] rd_re_r, rd_im_r;
  tw_t                        tw_c_r, tw_s_r;
  logic signed [PROD_W-1:0]   p_ac_r, p_bs_r, p_as_r, p_bc_r;
  logic signed [SUM_W-1:0]    sum_re_r, sum_im_r;
  logic signed [ACC_W-1:0]    acc_re_r, acc_im_r;
  logic signed [OUT_W-1:0]    out_real_r, out_imag_r;
  logic [GRID_LOG2-1:0]       k_nxt;

  // spectrum store: write on load, registered read during the sweep
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[{in_row, in_col}] <= {in_sample_real, in_sample_imag};
    end
    {rd_re_r, rd_im_r} <= mem[cnt_r];
  end

  // twiddle index steps by col each element and by row at each new grid row
  always_comb begin
    k_nxt = k_r + col_r;
    if (cnt_r[GRID_LOG2-1:0] == COL_LAST) begin
      k_nxt = k_nxt + row_r;
    end
  end

  // sweep address, twiddle index and output point
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      row_r <= in_row;
      col_r <= in_col;
      cnt_r <= '0;
      k_r   <= '0;
    end else if (cmd.issue) begin
      cnt_r <= cnt_r + ADDR_W'(1);
      k_r   <= k_nxt;
    end
  end

  assign sts.last_issue = (cnt_r == ADDR_LAST);

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // twiddle lookup, aligned with the store read
  always_ff @(posedge clk) begin
    tw_c_r <= TW_COS[k_r];
    tw_s_r <= TW_SIN[k_r];
  end

  // partial products
  always_ff @(posedge clk) begin
    p_ac_r <= PROD_W'(rd_re_r) * PROD_W'(tw_c_r);
    p_bs_r <= PROD_W'(rd_im_r) * PROD_W'(tw_s_r);
    p_as_r <= PROD_W'(rd_re_r) * PROD_W'(tw_s_r);
    p_bc_r <= PROD_W'(rd_im_r) * PROD_W'(tw_c_r);
  end

  // complex product terms
  always_ff @(posedge clk) begin
    sum_re_r <= SUM_W'(p_ac_r) - SUM_W'(p_bs_r);
    sum_im_r <= SUM_W'(p_as_r) + SUM_W'(p_bc_r);
  end

  // 48-bit wrapping accumulators
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v3_r) begin
      acc_re_r <= acc_re_r + {{(ACC_W-SUM_W){sum_re_r[SUM_W-1]}}, sum_re_r};
      acc_im_r <= acc_im_r + {{(ACC_W-SUM_W){sum_im_r[SUM_W-1]}}, sum_im_r};
    end
  end

  // normalized, saturated result
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_real_r <= norm_sat(acc_re_r);
      out_imag_r <= norm_sat(acc_im_r);
    end
  end

  assign out_real = out_real_r;
  assign out_imag = out_imag_r;

endmodule

// ----- sv/inverse_dft_2d_top.sv -----
// top level of the 2d inverse dft block
// Usage: a 16x16 complex spectrum is loaded one element per item and then
// output points of the inverse transform are requested one per item.
// Input channel: an item is taken when start is high and busy is low.
//   in_opcode load: in_sample_real/imag go to grid entry (in_row, in_col);
//   busy stays low, no result.
//   in_opcode compute: the point (z = in_row, x = in_col) is evaluated.
// A compute item sweeps all 256 stored entries, one complex multiply and
// accumulate per cycle through the store's single read port, then drains a
// three stage mac pipeline and normalizes: busy stays high throughout and
// out_valid pulses in the cycle in which busy is first low again.
// Sustained rate: one load per cycle; after a compute item no new item is
// accepted until its result is out.
// Result channel: out_real/out_imag are valid for exactly one cycle, marked
// by out_valid; the receiver cannot stall, and a new item may be accepted in
// that same cycle.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_valid; the spectrum store is not cleared and each entry must be
// loaded before any compute item reads it.
module inverse_dft_2d_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_opcode,
  input  logic [idft2d_pkg::GRID_LOG2-1:0]       in_row,
  input  logic [idft2d_pkg::GRID_LOG2-1:0]       in_col,
  input  logic signed [idft2d_pkg::SAMPLE_W-1:0] in_sample_real,
  input  logic signed [idft2d_pkg::SAMPLE_W-1:0] in_sample_imag,
  output logic                                   out_valid,
  output logic signed [idft2d_pkg::OUT_W-1:0]    out_real,
  output logic signed [idft2d_pkg::OUT_W-1:0]    out_imag
);
  import idft2d_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing
  idft2d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // store and arithmetic
  idft2d_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_sample_real (in_sample_real),
    .in_sample_imag (in_sample_imag),
    .out_real       (out_real),
    .out_imag       (out_imag)
  );

`ifndef SYNTHESIS
  // a load item never makes the block busy
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_LOAD) |=> !busy)
    else $error("load item left the block busy");

  // a compute item starts a sweep
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_COMPUTE) |=> busy)
    else $error("compute item did not start a sweep");

  // a result follows only the end of a sweep
  a_result_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result without a finished sweep");

  // out_valid is never high in back-to-back cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
`endif

endmodule
